// ----- design/assert_macros.svh -----
// assertion macros for the timer bank top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define STB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true outside reset
`define STB_NEVER(label, cond, msg) \
  `STB_ASSERT(label, !(cond), msg)

`endif

// ----- design/stb_pkg.sv -----
// types and constants shared by the timer bank modules
package stb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int NUM_TIMERS_MAX = 16;
  localparam int MAX_REPORTS    = 8;
  localparam int SVC_W          = $clog2(MAX_REPORTS);

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 4;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 3;

  // input actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_ALLOC   = 3'd1,
    ACT_START   = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_SERVICE = 3'd5,
    ACT_QUERY   = 3'd6
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_EXPIRY    = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RESP,
    S_SERVICE,
    S_EMIT
  } state_t;

  // entry store access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

// ----- design/stb_entry_store.sv -----
// per slot period and deadline memory with written flags, one read and one write port
module stb_entry_store #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stb_pkg::ram_ctl_t         ctl,
  input  logic [IDX_W-1:0]          rd_addr,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [stb_pkg::TICK_W-1:0] wr_period,
  input  logic [stb_pkg::TICK_W-1:0] wr_deadline,
  output logic [stb_pkg::TICK_W-1:0] rd_period,
  output logic [stb_pkg::TICK_W-1:0] rd_deadline
);
  import stb_pkg::*;

  logic [2*TICK_W-1:0]  mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] written;
  logic [2*TICK_W-1:0]  rd_data;
  logic                 rd_written;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ctl.wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // storage, read first
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_period, wr_deadline};
    end
    if (ctl.rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  assign rd_period   = rd_written ? rd_data[2*TICK_W-1:TICK_W] : '0;
  assign rd_deadline = rd_written ? rd_data[TICK_W-1:0]        : '0;

endmodule

// ----- design/software_timer_bank.sv -----
// software timer bank top level: sequencer, slot flags and result register
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid in_stall action timer_index period      | to block
//           | periodic                                         |
//   out     | out_valid out_stall status result_index          | from block
//           | elapsed_ticks last                               |
//
// one transaction is taken at a time; the block stalls its input until the
// last result of the current transaction is in the output register.
// tick walks every slot through the single read port of the entry store;
// start and query read one entry unless refused, allocate writes one when a
// slot is free; service gives one result per reported slot (at most 8), or
// one with nothing pending.
// output stalls hold the sequencer in place; reset is synchronous and clears
// the tick counter and all slot flags at once, with no clearing pass.
module software_timer_bank #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stb_pkg::ACTION_W-1:0]  action,
  input  logic [stb_pkg::INDEX_W-1:0]   timer_index,
  input  logic [stb_pkg::TICK_W-1:0]    period,
  input  logic                          periodic,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stb_pkg::STATUS_W-1:0]  status,
  output logic [stb_pkg::INDEX_W-1:0]   result_index,
  output logic [stb_pkg::TICK_W-1:0]    elapsed_ticks,
  output logic                          last
);
  import stb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [INDEX_W:0] SLOT_LIMIT = (INDEX_W+1)'(NUM_TIMERS);

  state_t state, state_next;

  // latched transaction
  action_t               act_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [TICK_W-1:0]     per_q;
  logic                  peri_q;

  // shared state
  logic [TICK_W-1:0]     tick_count;
  logic [NUM_TIMERS-1:0] in_use, running, auto_reload, expired;

  // sequencing
  logic [IDX_W-1:0]      scan_idx;
  logic [SVC_W-1:0]      svc_cnt;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_slot;

  // pending single result
  status_t               res_status;
  logic [INDEX_W-1:0]    res_index;
  logic [TICK_W-1:0]     res_elapsed;

  // output register
  status_t               out_status;
  logic [INDEX_W-1:0]    out_index;
  logic [TICK_W-1:0]     out_elapsed;
  logic                  out_last;

  // entry store port
  ram_ctl_t              ram_ctl;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [TICK_W-1:0]     wr_period, wr_deadline;
  logic [TICK_W-1:0]     rd_period, rd_deadline;

  // derived
  logic                  out_free;
  logic                  idx_ok;
  logic [IDX_W-1:0]      idx_slot;
  logic                  any_free;
  logic [IDX_W-1:0]      free_slot;
  logic [IDX_W-1:0]      exp_slot;
  logic [NUM_TIMERS-1:0] exp_rest;
  logic                  svc_last;
  logic [TICK_W-1:0]     reload_sum;
  logic [TICK_W-1:0]     elapsed_calc;
  logic                  tick_hit;

  stb_entry_store #(.NUM_TIMERS(NUM_TIMERS)) u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ram_ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wr_period   (wr_period),
    .wr_deadline (wr_deadline),
    .rd_period   (rd_period),
    .rd_deadline (rd_deadline)
  );

  assign out_free = !out_valid || !out_stall;
  assign idx_ok   = ({1'b0, idx_q} < SLOT_LIMIT);
  assign idx_slot = idx_q[IDX_W-1:0];

  // first free slot
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        any_free  = 1'b1;
        free_slot = IDX_W'(i);
      end
    end
  end

  // lowest expired slot and what is left behind it
  always_comb begin
    exp_slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (expired[i]) begin
        exp_slot = IDX_W'(i);
      end
    end
    exp_rest = expired & ~(NUM_TIMERS'(1) << exp_slot);
    svc_last = (exp_rest == '0) || (svc_cnt == SVC_W'(MAX_REPORTS - 1));
  end

  // deadline arithmetic on read data
  assign reload_sum   = tick_count + rd_period;
  assign elapsed_calc = (tick_count < rd_deadline) ?
                        (rd_period + tick_count - rd_deadline) : '0;
  assign tick_hit     = rd_vld && (act_q == ACT_TICK) && running[rd_slot] &&
                        (rd_deadline == tick_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (act_q)
          ACT_TICK:    state_next = S_SCAN;
          ACT_START:   state_next = (idx_ok && in_use[idx_slot]) ? S_RESP : S_EMIT;
          ACT_QUERY:   state_next = idx_ok ? S_RESP : S_EMIT;
          ACT_SERVICE: state_next = (|expired) ? S_SERVICE : S_EMIT;
          default:     state_next = S_EMIT;
        endcase
      end
      S_SCAN: begin
        if (scan_idx == IDX_W'(NUM_TIMERS - 1)) state_next = S_RESP;
      end
      S_RESP: state_next = S_EMIT;
      S_SERVICE: begin
        if (out_free && svc_last) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and entry store control
  always_comb begin
    in_stall    = (state != S_IDLE);
    ram_ctl     = '0;
    rd_addr     = '0;
    wr_addr     = rd_slot;
    wr_period   = rd_period;
    wr_deadline = reload_sum;
    unique case (state)
      S_DECODE: begin
        if (act_q == ACT_ALLOC && any_free) begin
          ram_ctl.wr_en = 1'b1;
          wr_addr       = free_slot;
          wr_period     = per_q;
          wr_deadline   = '0;
        end else if ((act_q == ACT_START && idx_ok && in_use[idx_slot]) ||
                     (act_q == ACT_QUERY && idx_ok)) begin
          ram_ctl.rd_en = 1'b1;
          rd_addr       = idx_slot;
        end
      end
      S_SCAN: begin
        ram_ctl.rd_en = 1'b1;
        rd_addr       = scan_idx;
      end
      S_RESP: begin
        if (act_q == ACT_START) ram_ctl.wr_en = 1'b1;
      end
      default: ;
    endcase
    // periodic reload on a deadline hit during the tick walk
    if (tick_hit && auto_reload[rd_slot]) ram_ctl.wr_en = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tick_count  <= '0;
      in_use      <= '0;
      running     <= '0;
      auto_reload <= '0;
      expired     <= '0;
      out_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      scan_idx    <= '0;
      svc_cnt     <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= ram_ctl.rd_en;

      // output register fills when a result is loaded, empties when taken
      if (out_free && (state == S_SERVICE || state == S_EMIT)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_DECODE: begin
          scan_idx <= '0;
          svc_cnt  <= '0;
          unique case (act_q)
            ACT_TICK: tick_count <= tick_count + 1'b1;
            ACT_ALLOC: begin
              if (any_free) begin
                in_use[free_slot]      <= 1'b1;
                running[free_slot]     <= 1'b0;
                expired[free_slot]     <= 1'b0;
                auto_reload[free_slot] <= peri_q;
              end
            end
            ACT_STOP: begin
              if (idx_ok) running[idx_slot] <= 1'b0;
            end
            ACT_RELEASE: begin
              if (idx_ok) begin
                in_use[idx_slot]      <= 1'b0;
                running[idx_slot]     <= 1'b0;
                auto_reload[idx_slot] <= 1'b0;
                expired[idx_slot]     <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: scan_idx <= scan_idx + 1'b1;
        S_RESP: begin
          if (act_q == ACT_START) running[rd_slot] <= 1'b1;
        end
        S_SERVICE: begin
          if (out_free) begin
            expired[exp_slot] <= 1'b0;
            if (!auto_reload[exp_slot]) running[exp_slot] <= 1'b0;
            svc_cnt           <= svc_cnt + 1'b1;
          end
        end
        default: ;
      endcase

      // deadline hit seen on the tick walk
      if (tick_hit) expired[rd_slot] <= 1'b1;
    end
  end

  // transaction latch, read tag, results
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_q  <= action_t'(action);
      idx_q  <= timer_index;
      per_q  <= period;
      peri_q <= periodic;
    end
    rd_slot <= rd_addr;

    unique case (state)
      S_DECODE: begin
        res_index   <= (act_q == ACT_ALLOC && any_free) ? INDEX_W'(free_slot) : '0;
        res_elapsed <= '0;
        unique case (act_q)
          ACT_ALLOC:   res_status <= any_free ? ST_DONE : ST_FULL;
          ACT_START:   res_status <= (idx_ok && in_use[idx_slot]) ? ST_DONE : ST_BAD_INDEX;
          ACT_STOP,
          ACT_RELEASE,
          ACT_QUERY:   res_status <= idx_ok ? ST_DONE : ST_BAD_INDEX;
          ACT_SERVICE: res_status <= ST_NONE;
          default:     res_status <= ST_DONE;
        endcase
      end
      S_RESP: begin
        if (act_q == ACT_QUERY) res_elapsed <= elapsed_calc;
      end
      S_SERVICE: begin
        if (out_free) begin
          out_status  <= ST_EXPIRY;
          out_index   <= INDEX_W'(exp_slot);
          out_elapsed <= '0;
          out_last    <= svc_last;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_status  <= res_status;
          out_index   <= res_index;
          out_elapsed <= res_elapsed;
          out_last    <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign status        = out_status;
  assign result_index  = out_index;
  assign elapsed_ticks = out_elapsed;
  assign last          = out_last;

  // checks
  `include "assert_macros.svh"

  `STB_NEVER(run_needs_use, |(running & ~in_use), "running slot is not allocated")
  `STB_NEVER(exp_needs_use, |(expired & ~in_use), "expired slot is not allocated")
  `STB_NEVER(ram_same_entry,
             ram_ctl.rd_en && ram_ctl.wr_en && (rd_addr == wr_addr),
             "read and write hit one entry")
  `STB_ASSERT(svc_has_work, (state == S_SERVICE) |-> (|expired),
              "service walk without expired slot")
  `STB_ASSERT(tick_walk_ends,
              (state == S_SCAN) && (state_next == S_RESP) |=> rd_vld,
              "tick walk lost its last read")

endmodule

// ----- dv/tb.sv -----
// self-checking testbench for the software timer bank
`timescale 1ns / 1ps

module tb;
  import stb_pkg::*;

  localparam int NUM_SLOTS    = NUM_TIMERS_DEF;
  localparam int RANDOM_ITEMS = 105;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 4 + 16;
  localparam int CYCLE_LIMIT  = 200_000;

  // action code the block does not decode
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  index;
    logic [TICK_W-1:0]   period;
    logic                periodic;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  slot;
    logic [TICK_W-1:0]   elapsed;
    logic                last;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = ACT_TICK;
  logic [INDEX_W-1:0]  timer_index = '0;
  logic [TICK_W-1:0]   period = '0;
  logic                periodic = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  result_index;
  logic [TICK_W-1:0]   elapsed_ticks;
  logic                last;

  // timer bank shadow state
  bit [TICK_W-1:0] tick_now;
  bit [TICK_W-1:0] slot_period   [NUM_SLOTS];
  bit [TICK_W-1:0] slot_deadline [NUM_SLOTS];
  bit              slot_alloc    [NUM_SLOTS];
  bit              slot_armed    [NUM_SLOTS];
  bit              slot_reload   [NUM_SLOTS];
  bit              slot_fired    [NUM_SLOTS];

  result_t  expected_results[$];
  dir_row_t directed_rows[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       calm_in = 1'b0;
  bit       calm_out = 1'b0;

  software_timer_bank #(.NUM_TIMERS(NUM_SLOTS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .timer_index  (timer_index),
    .period       (period),
    .periodic     (periodic),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_index (result_index),
    .elapsed_ticks(elapsed_ticks),
    .last         (last)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void push_result(status_t st, logic [INDEX_W-1:0] slot,
                                      logic [TICK_W-1:0] el, logic lst);
    expected_results.push_back('{st, slot, el, lst});
  endfunction

  // advance the shadow timer bank by one transaction and queue its results
  function automatic void predict_timer_bank(cmd_t c);
    bit [TICK_W-1:0] gone;
    int              reports;
    int              free_slot;
    bit              idx_ok;
    idx_ok = c.index < NUM_SLOTS;
    case (c.action)
      ACT_TICK: begin
        tick_now = tick_now + 1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_armed[s] && slot_deadline[s] == tick_now) begin
            slot_fired[s] = 1'b1;
            if (slot_reload[s]) slot_deadline[s] = tick_now + slot_period[s];
          end
        end
        push_result(ST_DONE, '0, '0, 1'b1);
      end
      ACT_ALLOC: begin
        free_slot = -1;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (!slot_alloc[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          slot_alloc[free_slot]    = 1'b1;
          slot_armed[free_slot]    = 1'b0;
          slot_fired[free_slot]    = 1'b0;
          slot_reload[free_slot]   = c.periodic;
          slot_period[free_slot]   = c.period;
          slot_deadline[free_slot] = '0;
          push_result(ST_DONE, INDEX_W'(free_slot), '0, 1'b1);
        end
      end
      ACT_START: begin
        if (!idx_ok || !slot_alloc[c.index]) begin
          push_result(ST_BAD_INDEX, '0, '0, 1'b1);
        end else begin
          slot_armed[c.index]    = 1'b1;
          slot_deadline[c.index] = tick_now + slot_period[c.index];
          push_result(ST_DONE, '0, '0, 1'b1);
        end
      end
      ACT_STOP: begin
        if (!idx_ok) begin
          push_result(ST_BAD_INDEX, '0, '0, 1'b1);
        end else begin
          slot_armed[c.index] = 1'b0;
          push_result(ST_DONE, '0, '0, 1'b1);
        end
      end
      ACT_RELEASE: begin
        if (!idx_ok) begin
          push_result(ST_BAD_INDEX, '0, '0, 1'b1);
        end else begin
          slot_alloc[c.index]  = 1'b0;
          slot_armed[c.index]  = 1'b0;
          slot_reload[c.index] = 1'b0;
          slot_fired[c.index]  = 1'b0;
          push_result(ST_DONE, '0, '0, 1'b1);
        end
      end
      ACT_SERVICE: begin
        reports = 0;
        for (int s = 0; s < NUM_SLOTS && reports < MAX_REPORTS; s++) begin
          if (slot_fired[s]) begin
            if (!slot_reload[s]) slot_armed[s] = 1'b0;
            slot_fired[s] = 1'b0;
            push_result(ST_EXPIRY, INDEX_W'(s), '0, 1'b0);
            reports++;
          end
        end
        if (reports == 0) push_result(ST_NONE, '0, '0, 1'b1);
        else expected_results[expected_results.size() - 1].last = 1'b1;
      end
      ACT_QUERY: begin
        if (!idx_ok) begin
          push_result(ST_BAD_INDEX, '0, '0, 1'b1);
        end else begin
          gone = '0;
          if (tick_now < slot_deadline[c.index])
            gone = slot_period[c.index] - (slot_deadline[c.index] - tick_now);
          push_result(ST_DONE, '0, gone, 1'b1);
        end
      end
      default: begin
        push_result(ST_DONE, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic dir_row_t plain_row(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                                         logic [TICK_W-1:0] per, logic peri);
    dir_row_t r;
    r = '0;
    r.cmd = '{act, idx, per, peri};
    return r;
  endfunction

  function automatic dir_row_t checked_row(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                                           logic [TICK_W-1:0] per, logic peri, status_t st,
                                           logic [INDEX_W-1:0] slot, logic [TICK_W-1:0] el);
    dir_row_t r;
    r = plain_row(act, idx, per, peri);
    r.typed = 1'b1;
    r.want = '{st, slot, el, 1'b1};
    return r;
  endfunction

  // present one transaction after a random gap, starting and ending at a falling edge
  task automatic drive_item(input cmd_t c, input logic typed, input result_t want);
    int gap;
    int first;
    if ($urandom_range(0, 11) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= c.action;
    timer_index <= c.index;
    period      <= c.period;
    periodic    <= c.periodic;
    do @(posedge clk); while (in_stall);
    first = expected_results.size();
    predict_timer_bank(c);
    if (typed) expected_results[first] = want;
    @(negedge clk);
  endtask

  // result side stalls
  initial begin : result_sink
    int hold;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d", status, result_index);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (result_index !== want.slot) begin
          $error("result_index: expected %0d, got %0d", want.slot, result_index);
          mismatches++;
        end
        if (elapsed_ticks !== want.elapsed) begin
          $error("elapsed_ticks: expected %0d, got %0d", want.elapsed, elapsed_ticks);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int                  roll;
    int                  live[$];
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    logic [TICK_W-1:0]   per;
    directed_rows = '{
      // fresh after reset: nothing pending, unarmed slot reads zero
      checked_row(ACT_SERVICE, 4'd0, 32'd0, 1'b0, ST_NONE, 4'd0, 32'd0),
      checked_row(ACT_QUERY, 4'd0, 32'd0, 1'b0, ST_DONE, 4'd0, 32'd0),
      // free slot and out of range slot
      checked_row(ACT_START, 4'd0, 32'd0, 1'b0, ST_BAD_INDEX, 4'd0, 32'd0),
      checked_row(ACT_STOP, 4'd15, 32'd0, 1'b1, ST_BAD_INDEX, 4'd0, 32'd0),
      checked_row(ACT_RELEASE, 4'd3, 32'd0, 1'b0, ST_DONE, 4'd0, 32'd0),
      // first slots with short, maximum and zero periods in both modes
      checked_row(ACT_ALLOC, 4'd0, 32'd2, 1'b1, ST_DONE, 4'd0, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd3, 1'b0, ST_DONE, 4'd1, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'hffff_ffff, 1'b1, ST_DONE, 4'd2, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd0, 1'b0, ST_DONE, 4'd3, 32'd0),
      plain_row(ACT_START, 4'd0, 32'd0, 1'b0),
      plain_row(ACT_START, 4'd1, 32'd0, 1'b0),
      plain_row(ACT_START, 4'd2, 32'd0, 1'b0),
      checked_row(ACT_QUERY, 4'd9, 32'd0, 1'b0, ST_BAD_INDEX, 4'd0, 32'd0),
      // run the counter until two slots expire
      plain_row(ACT_TICK, 4'd0, 32'd0, 1'b0),
      plain_row(ACT_TICK, 4'd0, 32'd0, 1'b0),
      plain_row(ACT_QUERY, 4'd1, 32'd0, 1'b0),
      plain_row(ACT_TICK, 4'd0, 32'd0, 1'b0),
      // a stopped slot keeps its expiry mark
      plain_row(ACT_STOP, 4'd0, 32'd0, 1'b0),
      plain_row(ACT_SERVICE, 4'd0, 32'd0, 1'b0),
      checked_row(ACT_UNUSED, 4'd7, 32'hffff_ffff, 1'b1, ST_DONE, 4'd0, 32'd0),
      // fill the table, then overflow it
      checked_row(ACT_ALLOC, 4'd0, 32'd1, 1'b1, ST_DONE, 4'd4, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd4, 1'b0, ST_DONE, 4'd5, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd5, 1'b1, ST_DONE, 4'd6, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd6, 1'b0, ST_DONE, 4'd7, 32'd0),
      checked_row(ACT_ALLOC, 4'd0, 32'd7, 1'b1, ST_FULL, 4'd0, 32'd0)
    };

    // reset
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r])
      drive_item(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

    // random mix, mostly aimed at allocated slots with short periods
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 34) act = ACT_TICK;
      else if (roll < 44) act = ACT_ALLOC;
      else if (roll < 56) act = ACT_START;
      else if (roll < 62) act = ACT_STOP;
      else if (roll < 69) act = ACT_RELEASE;
      else if (roll < 84) act = ACT_SERVICE;
      else if (roll < 97) act = ACT_QUERY;
      else act = ACT_UNUSED;

      live.delete();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (slot_alloc[s]) live.push_back(s);
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) idx = INDEX_W'($urandom_range(NUM_SLOTS, 15));
      else if (roll < 80 && live.size() > 0)
        idx = INDEX_W'(live[$urandom_range(0, live.size() - 1)]);
      else idx = INDEX_W'($urandom_range(0, NUM_SLOTS - 1));

      roll = $urandom_range(0, 99);
      if (roll < 10) per = '0;
      else if (roll < 20) per = $urandom;
      else per = $urandom_range(1, 6);

      drive_item('{act, idx, per, 1'($urandom_range(0, 1))}, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
